### hdl/dsib_pkg.sv
// Shared types and constants of the depth-sorted insert buffer.
// No dependencies; imported by the key unit, the cell and the top level.
package dsib_pkg;

    localparam int DEPTH    = 64;
    localparam int ID_BITS  = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam int POS_W    = 24;
    localparam int COEF_W   = 18;
    localparam int OFS_W    = 24;
    localparam int KEY_W    = 32;
    localparam int OUT_ID_W = 16;
    localparam int FILL_W   = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // coef*position, then sum of three products and offset, with headroom
    localparam int PROD_W   = COEF_W + POS_W;
    localparam int SUM_W    = PROD_W + 4;
    localparam int FRAC_SH  = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(3);

    localparam logic signed [COEF_W-1:0] COEF_X_RST = COEF_W'(0);
    localparam logic signed [COEF_W-1:0] COEF_Y_RST = COEF_W'(0);
    localparam logic signed [COEF_W-1:0] COEF_Z_RST = COEF_W'(32768);
    localparam logic signed [OFS_W-1:0]  OFFSET_RST = OFS_W'(0);

    localparam logic [CFG_DATA_W-1:0] CFG_UNUSED = '0;

    // operations issued to every cell of the chain
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_SHL  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ID_BITS-1:0] id;
    } cell_data_t;

    typedef struct packed {
        logic [1:0] op;
        cell_data_t item;
    } cell_ctrl_t;

endpackage

### hdl/depth_sorted_insert_buffer.sv
// Depth-sorted insert buffer: key pipeline, chain of DEPTH cells, output register.
// Insert: result registered after key pipeline and free output; items do not overlap.
// Drain of n entries: one result per cycle while accepted, n in all (one if empty).
// Throughput is set by the 3-stage key multiply-round pipeline plus the chain shift.
// Reset (aresetn low, synchronous) clears count, FSM, output valid and config registers;
// entry storage is not cleared.
module depth_sorted_insert_buffer
    import dsib_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_opcode,
    input  logic [15:0]              s_item_id,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_y,
    input  logic signed [POS_W-1:0]  s_pos_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [OUT_ID_W-1:0]      m_out_id,
    output logic signed [KEY_W-1:0]  m_out_key,
    output logic                     m_accepted,
    output logic                     m_is_empty,
    output logic [FILL_W-1:0]        m_fill_count,
    output logic                     m_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_KEY   = 2'd1;
    localparam logic [1:0] ST_INS   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ID_BITS-1:0] id_reg;

    logic signed [COEF_W-1:0] coef_x_reg, coef_y_reg, coef_z_reg;
    logic signed [OFS_W-1:0]  offset_reg;

    logic              m_valid_reg, m_valid_next;
    logic [OUT_ID_W-1:0] out_id_reg, out_id_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic              out_acc_reg, out_acc_next;
    logic              out_empty_reg, out_empty_next;
    logic [FILL_W-1:0] out_fill_reg, out_fill_next;
    logic              out_last_reg, out_last_next;

    logic s_accept, out_free, key_start, key_vld, has_room;
    logic [KEY_W-1:0] key;
    cell_ctrl_t ctrl;
    cell_data_t cell_q [DEPTH];
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] occ;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign key_start = s_accept && !s_opcode;
    assign out_free  = !m_valid_reg || m_ready;
    assign has_room  = (count_reg < CNT_W'(DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_x_reg <= COEF_X_RST;
            coef_y_reg <= COEF_Y_RST;
            coef_z_reg <= COEF_Z_RST;
            offset_reg <= OFFSET_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_COEF_X: coef_x_reg <= cfg_data[COEF_W-1:0];
                REG_COEF_Y: coef_y_reg <= cfg_data[COEF_W-1:0];
                REG_COEF_Z: coef_z_reg <= cfg_data[COEF_W-1:0];
                REG_OFFSET: offset_reg <= cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    dsib_key_unit u_key (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (key_start),
        .pos_x   (s_pos_x),
        .pos_y   (s_pos_y),
        .pos_z   (s_pos_z),
        .coef_x  (coef_x_reg),
        .coef_y  (coef_y_reg),
        .coef_z  (coef_z_reg),
        .offset  (offset_reg),
        .key_vld (key_vld),
        .key     (key)
    );

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            cell_data_t left_d, right_d;
            logic       left_g;
            assign occ[gi] = (CNT_W'(gi) < count_reg);
            if (gi == 0) begin : g_head
                assign left_d = '0;
                assign left_g = 1'b1;
            end else begin : g_body
                assign left_d = cell_q[gi-1];
                assign left_g = ge[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign right_d = '0;
            end else begin : g_mid
                assign right_d = cell_q[gi+1];
            end
            dsib_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occ        (occ[gi]),
                .left_data  (left_d),
                .left_ge    (left_g),
                .right_data (right_d),
                .data       (cell_q[gi]),
                .ge         (ge[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.item.key  = key;
        ctrl.item.id   = id_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_id_next    = out_id_reg;
        out_key_next   = out_key_reg;
        out_acc_next   = out_acc_reg;
        out_empty_next = out_empty_reg;
        out_fill_next  = out_fill_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = s_opcode ? ST_DRAIN : ST_KEY;
                end
            end
            ST_KEY: begin
                if (key_vld) begin
                    state_next = ST_INS;
                end
            end
            ST_INS: begin
                // hold the key until the output slot frees
                if (out_free) begin
                    if (has_room) begin
                        ctrl.op    = CELL_INS;
                        count_next = count_reg + CNT_W'(1);
                    end
                    m_valid_next   = 1'b1;
                    out_id_next    = OUT_ID_W'(id_reg);
                    out_key_next   = key;
                    out_acc_next   = has_room;
                    out_empty_next = 1'b0;
                    out_fill_next  = FILL_W'(count_next);
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_acc_next   = 1'b0;
                    out_fill_next  = '0;
                    if (count_reg == '0) begin
                        out_id_next    = '0;
                        out_key_next   = '0;
                        out_empty_next = 1'b1;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        // emit the head entry and advance the chain
                        ctrl.op        = CELL_SHL;
                        out_id_next    = OUT_ID_W'(cell_q[0].id);
                        out_key_next   = cell_q[0].key;
                        out_empty_next = 1'b0;
                        out_last_next  = (count_reg == CNT_W'(1));
                        count_next     = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            id_reg <= ID_BITS'(s_item_id);
        end
        out_id_reg    <= out_id_next;
        out_key_reg   <= out_key_next;
        out_acc_reg   <= out_acc_next;
        out_empty_reg <= out_empty_next;
        out_fill_reg  <= out_fill_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_id     = out_id_reg;
    assign m_out_key    = out_key_reg;
    assign m_accepted   = out_acc_reg;
    assign m_is_empty   = out_empty_reg;
    assign m_fill_count = out_fill_reg;
    assign m_last       = out_last_reg;

endmodule

### hdl/dsib_key_unit.sv
// Depth key pipeline: three products, sum with offset, round half to even,
// saturate to 32 bits. Depends on dsib_pkg.
module dsib_key_unit
    import dsib_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic signed [COEF_W-1:0] coef_x,
    input  logic signed [COEF_W-1:0] coef_y,
    input  logic signed [COEF_W-1:0] coef_z,
    input  logic signed [OFS_W-1:0]  offset,
    output logic                     key_vld,
    output logic [KEY_W-1:0]         key
);

    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [SUM_W-1:0]  ofs_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic                     v1_reg, v2_reg, v3_reg;

    logic signed [SUM_W-FRAC_SH-1:0] quo;
    logic [FRAC_SH-1:0]              rem;
    logic                            rnd_up;
    logic signed [KEY_W:0]           rounded;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg  <= coef_x * pos_x;
        py_reg  <= coef_y * pos_y;
        pz_reg  <= coef_z * pos_z;
        ofs_reg <= SUM_W'(offset) <<< FRAC_SH;
        sum_reg <= sum_next;
        // hold the key until the next transaction reaches the last stage
        if (v2_reg) begin
            key_reg <= key_next;
        end
    end

    assign sum_next = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg) + ofs_reg;

    // round to nearest, ties to even, then clamp
    always_comb begin
        quo     = sum_reg[SUM_W-1:FRAC_SH];
        rem     = sum_reg[FRAC_SH-1:0];
        rnd_up  = (rem > {1'b1, {(FRAC_SH-1){1'b0}}})
               || ((rem == {1'b1, {(FRAC_SH-1){1'b0}}}) && quo[0]);
        rounded = (KEY_W+1)'(quo) + (KEY_W+1)'(rnd_up);
        if (rounded[KEY_W] != rounded[KEY_W-1]) begin
            key_next = rounded[KEY_W] ? {1'b1, {(KEY_W-1){1'b0}}}
                                      : {1'b0, {(KEY_W-1){1'b1}}};
        end else begin
            key_next = rounded[KEY_W-1:0];
        end
    end

    assign key_vld = v3_reg;
    assign key     = key_reg;

endmodule

### hdl/dsib_cell.sv
// One slot of the sorted chain: holds a key and id, compares against the
// broadcast item and takes data from either neighbor. Depends on dsib_pkg.
module dsib_cell
    import dsib_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occ,
    input  cell_data_t left_data,
    input  logic       left_ge,
    input  cell_data_t right_data,
    output cell_data_t data,
    output logic       ge
);

    cell_data_t data_reg, data_next;

    // entry sorts ahead of the new item (equal keys stay ahead)
    assign ge = occ && ($signed(data_reg.key) >= $signed(ctrl.item.key));

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (!ge) begin
                    data_next = left_ge ? ctrl.item : left_data;
                end
            end
            CELL_SHL: data_next = right_data;
            default:  data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench of the depth-sorted insert buffer: inserts, drains and depth-row writes under
// random valid/ready gaps, each result checked against a predictor of the sorted buffer.
// Depends on dsib_pkg and depth_sorted_insert_buffer.
module tb_top;
    import dsib_pkg::*;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam int IDLE_PCT    = 36;
    localparam int TAIL_CYCLES = 20;
    localparam int ITEM_TARGET = 350;

    localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [OFS_W-1:0]  OFS_MAX  = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic signed [OFS_W-1:0]  OFS_MIN  = {1'b1, {(OFS_W-1){1'b0}}};

    localparam longint KEY_HI   = 64'sd2147483647;
    localparam longint KEY_LO   = -64'sd2147483648;
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_SH - 1);

    typedef struct packed {
        logic                    opcode;
        logic [15:0]             id;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
    } depth_cmd_t;

    typedef struct packed {
        logic [OUT_ID_W-1:0] id;
        logic [KEY_W-1:0]    key;
        logic                accepted;
        logic                is_empty;
        logic [FILL_W-1:0]   fill;
        logic                last;
    } sort_result_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic                     s_opcode  = 1'b0;
    logic [15:0]              s_item_id = '0;
    logic signed [POS_W-1:0]  s_pos_x   = '0;
    logic signed [POS_W-1:0]  s_pos_y   = '0;
    logic signed [POS_W-1:0]  s_pos_z   = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic [OUT_ID_W-1:0]      m_out_id;
    logic signed [KEY_W-1:0]  m_out_key;
    logic                     m_accepted;
    logic                     m_is_empty;
    logic [FILL_W-1:0]        m_fill_count;
    logic                     m_last;

    // predictor copy of the depth row and of the sorted contents
    logic signed [COEF_W-1:0] row_coef_x = COEF_X_RST;
    logic signed [COEF_W-1:0] row_coef_y = COEF_Y_RST;
    logic signed [COEF_W-1:0] row_coef_z = COEF_Z_RST;
    logic signed [OFS_W-1:0]  row_offset = OFFSET_RST;
    logic signed [KEY_W-1:0]  sorted_keys [DEPTH];
    logic [ID_BITS-1:0]       sorted_ids  [DEPTH];
    int                       sorted_count = 0;

    sort_result_t pending_results [$];
    int           error_count = 0;
    int           items_sent  = 0;
    logic         no_idle     = 1'b0;

    depth_sorted_insert_buffer uut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge aclk) m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    function automatic logic signed [KEY_W-1:0] compute_depth_key(
        input logic signed [POS_W-1:0] px,
        input logic signed [POS_W-1:0] py,
        input logic signed [POS_W-1:0] pz
    );
        longint sum;
        longint q;
        longint r;
        sum = longint'(row_coef_x) * longint'(px) + longint'(row_coef_y) * longint'(py)
            + longint'(row_coef_z) * longint'(pz) + (longint'(row_offset) <<< FRAC_SH);
        q = sum >>> FRAC_SH;
        r = sum - (q <<< FRAC_SH);
        // round half to even
        if (r > ROUND_HALF || (r == ROUND_HALF && q[0]))
            q = q + 1;
        if (q > KEY_HI)
            q = KEY_HI;
        if (q < KEY_LO)
            q = KEY_LO;
        return KEY_W'(q);
    endfunction

    function automatic void predict_cmd(input depth_cmd_t cmd);
        sort_result_t r;
        logic signed [KEY_W-1:0] key;
        int p;
        if (cmd.opcode == OP_INSERT) begin
            key = compute_depth_key(cmd.px, cmd.py, cmd.pz);
            r = '0;
            r.id = OUT_ID_W'(ID_BITS'(cmd.id));
            r.key = key;
            r.last = 1'b1;
            if (sorted_count < DEPTH) begin
                // place after every key that is greater or equal
                p = 0;
                while (p < sorted_count && sorted_keys[p] >= key)
                    p++;
                for (int i = sorted_count; i > p; i--) begin
                    sorted_keys[i] = sorted_keys[i-1];
                    sorted_ids[i]  = sorted_ids[i-1];
                end
                sorted_keys[p] = key;
                sorted_ids[p]  = ID_BITS'(cmd.id);
                sorted_count++;
                r.accepted = 1'b1;
            end
            r.fill = FILL_W'(sorted_count);
            pending_results.push_back(r);
        end else if (sorted_count == 0) begin
            r = '0;
            r.is_empty = 1'b1;
            r.last = 1'b1;
            pending_results.push_back(r);
        end else begin
            for (int i = 0; i < sorted_count; i++) begin
                r = '0;
                r.id = OUT_ID_W'(sorted_ids[i]);
                r.key = sorted_keys[i];
                r.last = (i == sorted_count - 1);
                pending_results.push_back(r);
            end
            sorted_count = 0;
        end
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        sort_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result, expected none, actual id %0d key %0d last %0b",
                         $time, m_out_id, m_out_key, m_last);
            end else begin
                want = pending_results.pop_front();
                check_field("out_id", want.id, m_out_id);
                check_field("out_key", longint'(signed'(want.key)), longint'(m_out_key));
                check_field("accepted", want.accepted, m_accepted);
                check_field("is_empty", want.is_empty, m_is_empty);
                check_field("fill_count", want.fill, m_fill_count);
                check_field("last", want.last, m_last);
            end
        end
    end

    // valid stays high from one transaction to the next unless an idle cycle is drawn
    task automatic send_cmd(input depth_cmd_t cmd);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        predict_cmd(cmd);
        s_valid   <= 1'b1;
        s_opcode  <= cmd.opcode;
        s_item_id <= cmd.id;
        s_pos_x   <= cmd.px;
        s_pos_y   <= cmd.py;
        s_pos_z   <= cmd.pz;
        items_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic insert_item(input logic [15:0] id, input logic signed [POS_W-1:0] px,
                               input logic signed [POS_W-1:0] py,
                               input logic signed [POS_W-1:0] pz);
        send_cmd('{OP_INSERT, id, px, py, pz});
    endtask

    task automatic drain_all();
        send_cmd('{OP_DRAIN, 16'($urandom), POS_W'($urandom), POS_W'($urandom),
                   POS_W'($urandom)});
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_COEF_X: row_coef_x = data[COEF_W-1:0];
            REG_COEF_Y: row_coef_y = data[COEF_W-1:0];
            REG_COEF_Z: row_coef_z = data[COEF_W-1:0];
            REG_OFFSET: row_offset = data[OFS_W-1:0];
            default: ;
        endcase
    endtask

    // block must be idle: flush every result before touching the row
    task automatic set_depth_row(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                                 input logic [CFG_DATA_W-1:0] cz, input logic [CFG_DATA_W-1:0] ofs,
                                 input bit stray);
        wait_drained();
        write_reg(REG_COEF_X, cx);
        write_reg(REG_COEF_Y, cy);
        write_reg(REG_COEF_Z, cz);
        write_reg(REG_OFFSET, ofs);
        if (stray)
            write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_OFFSET + 1)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    // random bits above the register width must be ignored
    function automatic logic [CFG_DATA_W-1:0] pad_word(input logic [CFG_DATA_W-1:0] v,
                                                       input int w);
        logic [CFG_DATA_W-1:0] mask;
        mask = (CFG_DATA_W'(1) << w) - 1;
        return (CFG_DATA_W'($urandom) & ~mask) | (v & mask);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_coef();
        logic signed [COEF_W-1:0] c;
        case ($urandom_range(6))
            0: c = COEF_MIN;
            1: c = COEF_MAX;
            2: c = '0;
            3: c = COEF_W'(int'($urandom_range(128)) - 64);
            4: c = $urandom_range(1) ? COEF_Z_RST : -COEF_Z_RST;
            default: c = COEF_W'($urandom);
        endcase
        return pad_word(CFG_DATA_W'(c), COEF_W);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_offset();
        logic signed [OFS_W-1:0] o;
        case ($urandom_range(4))
            0: o = OFS_MIN;
            1: o = OFS_MAX;
            2: o = '0;
            default: o = OFS_W'($urandom);
        endcase
        return pad_word(CFG_DATA_W'(o), OFS_W);
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(7))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return POS_W'(int'($urandom_range(2048)) - 1024);
            default: return POS_W'($urandom);
        endcase
    endfunction

    task automatic randomize_row();
        set_depth_row(rand_coef(), rand_coef(), rand_coef(), rand_offset(),
                      $urandom_range(2) == 0);
    endtask

    // random inserts, repeated positions now and then to force equal keys, then drains
    task automatic run_random_set(input int n_items);
        depth_cmd_t cmd;
        cmd = '0;
        for (int i = 0; i < n_items; i++) begin
            if (i == 0 || $urandom_range(3) != 0) begin
                cmd.px = rand_pos();
                cmd.py = rand_pos();
                cmd.pz = rand_pos();
            end
            cmd.opcode = OP_INSERT;
            cmd.id = 16'($urandom);
            send_cmd(cmd);
        end
        drain_all();
        if ($urandom_range(9) == 0)
            drain_all();
    endtask

    function automatic int pick_set_size();
        case ($urandom_range(19))
            0: return 0;
            1: return $urandom_range(40, 13);
            default: return $urandom_range(12, 1);
        endcase
    endfunction

    task automatic test_empty_drain();
        drain_all();
    endtask

    task automatic test_key_extremes();
        // reset row: key is pos_z rounded
        insert_item(16'h0000, POS_MIN, POS_MAX, POS_MAX);
        insert_item(16'hFFFF, POS_MAX, POS_MIN, POS_MIN);
        insert_item(16'h5A5A, '0, '0, '0);
        drain_all();
        set_depth_row(CFG_DATA_W'(COEF_MIN), CFG_DATA_W'(COEF_MAX), CFG_DATA_W'(COEF_MIN),
                      CFG_DATA_W'(OFS_MAX), 1'b0);
        insert_item(16'h8001, POS_MAX, POS_MAX, POS_MIN);
        insert_item(16'h7FFE, POS_MIN, POS_MIN, POS_MAX);
        insert_item(16'h1234, POS_MIN, POS_MIN, POS_MIN);
        drain_all();
        set_depth_row(CFG_DATA_W'(COEF_MAX), CFG_DATA_W'(COEF_MAX), CFG_DATA_W'(COEF_MAX),
                      CFG_DATA_W'(OFS_MIN), 1'b0);
        insert_item(16'hA5A5, POS_MAX, POS_MAX, POS_MAX);
        insert_item(16'hC3C3, POS_MIN, POS_MIN, POS_MIN);
        drain_all();
    endtask

    task automatic test_rounding();
        // weight of one LSB on x: remainders land on half, then just above and below it
        set_depth_row(CFG_DATA_W'(1), '0, '0, '0, 1'b0);
        insert_item(16'd1, POS_W'(16384), POS_MAX, POS_MIN);
        insert_item(16'd2, POS_W'(49152), POS_MIN, POS_MAX);
        insert_item(16'd3, -POS_W'(16384), '0, '0);
        insert_item(16'd4, -POS_W'(49152), '0, '0);
        insert_item(16'd5, POS_W'(16385), '0, '0);
        insert_item(16'd6, POS_W'(16383), '0, '0);
        drain_all();
    endtask

    task automatic test_equal_keys();
        // zero weights: every key equals the offset, order must follow arrival
        set_depth_row(pad_word('0, COEF_W), pad_word('0, COEF_W), pad_word('0, COEF_W),
                      pad_word(CFG_DATA_W'(-1000), OFS_W), 1'b1);
        for (int i = 0; i < 4; i++)
            insert_item(16'($urandom), rand_pos(), rand_pos(), rand_pos());
        drain_all();
    endtask

    task automatic test_full_buffer();
        randomize_row();
        run_random_set(DEPTH + 3);
    endtask

    task automatic test_back_to_back();
        no_idle <= 1'b1;
        run_random_set(12);
        run_random_set(20);
        run_random_set(6);
        wait_drained();
        no_idle <= 1'b0;
    endtask

    task automatic test_random_sets();
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(2) == 0)
                randomize_row();
            run_random_set(pick_set_size());
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_drain();
        test_key_extremes();
        test_rounding();
        test_equal_keys();
        test_full_buffer();
        test_back_to_back();
        test_random_sets();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
